FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active low).
`define BPL_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BPL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/bpl_pkg.sv
// ---------------------------------------------------------------------------
// bpl_pkg - shared types and constants of the bounded positional list
// Function and status codes, cell control word and field widths.
// ---------------------------------------------------------------------------
package bpl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int POS_W        = 6;
    localparam int STAT_W       = 2;
    localparam int LEN_W        = 7;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_END   = 3'd1,
        FN_ERA_FRONT = 3'd2,
        FN_ERA_END   = 3'd3,
        FN_INS_POS   = 3'd4,
        FN_ERA_POS   = 3'd5,
        FN_READ      = 3'd6,
        FN_NOP       = 3'd7
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CM_HOLD = 2'd0,
        CM_INS  = 2'd1,
        CM_DEL  = 2'd2,
        CM_ROT  = 2'd3
    } cell_mode_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // Broadcast to every cell of the chain each cycle.
    typedef struct packed {
        cell_mode_t          mode;
        logic [LEN_W-1:0]    idx;    // insert / erase position, 0-based
        logic [LEN_W-1:0]    tail;   // last occupied cell during read-out
        logic [DATA_W-1:0]   value;  // value to insert
    } cell_ctrl_t;

endpackage

FILE: rtl/bpl_cell.sv
// ---------------------------------------------------------------------------
// bpl_cell - one storage cell of the list chain
// Holds one element; shifts in from a neighbor, loads the new value,
// or takes the head element when the chain rotates.
// ---------------------------------------------------------------------------
module bpl_cell
    import bpl_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [DATA_W-1:0] next_data,
    input  logic [DATA_W-1:0] head_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.mode)
            CM_INS: begin
                if (MY_IDX == ctrl.idx) begin
                    data_next = ctrl.value;
                end else if (MY_IDX > ctrl.idx) begin
                    data_next = prev_data;
                end
            end
            CM_DEL: begin
                if (MY_IDX >= ctrl.idx) begin
                    data_next = next_data;
                end
            end
            CM_ROT: begin
                // wrap the head into the tail cell, shift the rest forward
                if (MY_IDX == ctrl.tail) begin
                    data_next = head_data;
                end else if (MY_IDX < ctrl.tail) begin
                    data_next = next_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/bounded_positional_list.sv
// ---------------------------------------------------------------------------
// bounded_positional_list - ordered list with positional insert and erase
// Holds up to CAPACITY signed 32-bit values in a chain of shifting cells.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: func, position, value
//  m_      | out | m_tvalid/m_tready  | m_tdata: element, status, length; m_tlast
//
//  Insert, erase and no-op requests complete at accept: the cell chain shifts in
//  parallel and the status item is loaded into the output register at accept.
//  A read-out of N elements holds the input until all N items are sent, one
//  item per cycle while the output is not stalled, set by the rotation of
//  the chain through cell 0.
//  The input is not taken during a read-out or while the output register is
//  full and stalled. Reset empties the list; cell contents are not cleared.
//
`include "assert_macros.svh"

module bounded_positional_list
    import bpl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] func, [8:3] position, [40:9] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] element, [33:32] status,
                                              // [40:34] length
    output logic                   m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    // input field split
    func_t               in_func;
    logic [POS_W-1:0]    in_pos;
    logic [DATA_W-1:0]   in_value;

    assign in_func  = func_t'(s_tdata[FUNC_W-1:0]);
    assign in_pos   = s_tdata[FUNC_W +: POS_W];
    assign in_value = s_tdata[FUNC_W+POS_W +: DATA_W];

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rem_reg,   rem_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   elem_reg;
    status_t             status_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                last_reg;

    // chain
    cell_ctrl_t          ctrl;
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   head_data;

    // handshake helpers
    logic                out_free;
    logic                s_accept;

    // request decode
    logic [LEN_W-1:0]    count7;
    logic [LEN_W-1:0]    pos7;
    logic                full;
    logic                empty;
    cell_mode_t          d_mode;
    logic [LEN_W-1:0]    d_idx;
    status_t             d_status;
    logic                d_read;

    // item to load into the output register
    logic                emit;
    logic [DATA_W-1:0]   emit_elem;
    status_t             emit_status;
    logic                emit_last;

    assign out_free = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign head_data = cell_data[0];

    assign count7 = LEN_W'(count_reg);
    assign pos7   = LEN_W'(in_pos);
    assign full   = (count7 == LEN_W'(CAPACITY));
    assign empty  = (count7 == '0);

    // Decode the request against the current length: pick the shift the
    // chain makes and the status it reports.
    always_comb begin
        d_mode   = CM_HOLD;
        d_idx    = '0;
        d_status = STAT_OK;
        d_read   = 1'b0;
        unique case (in_func) inside
            FN_INS_FRONT, FN_INS_END: begin
                if (full) begin
                    d_status = STAT_FULL;
                end else begin
                    d_mode = CM_INS;
                    d_idx  = (in_func == FN_INS_FRONT) ? '0 : count7;
                end
            end
            FN_ERA_FRONT, FN_ERA_END: begin
                if (empty) begin
                    d_status = STAT_EMPTY;
                end else begin
                    d_mode = CM_DEL;
                    d_idx  = (in_func == FN_ERA_FRONT) ? '0 : count7 - 1'b1;
                end
            end
            FN_INS_POS: begin
                // range check wins over the full check
                if (pos7 == '0 || pos7 > count7 + 1'b1) begin
                    d_status = STAT_RANGE;
                end else if (full) begin
                    d_status = STAT_FULL;
                end else begin
                    d_mode = CM_INS;
                    d_idx  = pos7 - 1'b1;
                end
            end
            FN_ERA_POS: begin
                if (empty) begin
                    d_status = STAT_EMPTY;
                end else if (pos7 == '0 || pos7 > count7) begin
                    d_status = STAT_RANGE;
                end else begin
                    d_mode = CM_DEL;
                    d_idx  = pos7 - 1'b1;
                end
            end
            FN_READ: begin
                // empty list answers with a single empty item
                if (empty) begin
                    d_status = STAT_EMPTY;
                end else begin
                    d_read = 1'b1;
                end
            end
            FN_NOP: begin
                d_status = STAT_OK;
            end
            default: begin
                d_status = STAT_OK;
            end
        endcase
    end

    // Outputs of the controller: ready, chain command, output load.
    always_comb begin
        s_tready    = 1'b0;
        ctrl.mode   = CM_HOLD;
        ctrl.idx    = d_idx;
        ctrl.tail   = count7 - 1'b1;
        ctrl.value  = in_value;
        emit        = 1'b0;
        emit_elem   = '0;
        emit_status = STAT_OK;
        emit_last   = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = out_free;
                if (s_accept) begin
                    ctrl.mode   = d_mode;
                    emit        = !d_read;
                    emit_status = d_status;
                end
            end
            S_READ: begin
                // rotate one step per item sent; after count steps the list
                // is back in its original order
                if (out_free) begin
                    ctrl.mode = CM_ROT;
                    emit      = 1'b1;
                    emit_elem = head_data;
                    emit_last = (rem_reg == CW'(1));
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Next state, length and read-out counter.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (d_read) begin
                        state_next = S_READ;
                        rem_next   = count_reg;
                    end
                    if (d_mode == CM_INS) begin
                        count_next = count_reg + 1'b1;
                    end else if (d_mode == CM_DEL) begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold a stalled item, drop it once taken
    assign m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            elem_reg   <= emit_elem;
            status_reg <= emit_status;
            len_reg    <= LEN_W'(count_next);
            last_reg   <= emit_last;
        end
    end

    // Cell chain: cell i reads its neighbors i-1 and i+1 and the head.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;
        if (gi == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid_prev
            assign prev_d = cell_data[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_mid_next
            assign next_d = cell_data[gi+1];
        end
        bpl_cell #(
            .INDEX(gi)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (head_data),
            .data      (cell_data[gi])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DATA_W - STAT_W - LEN_W){1'b0}},
                       len_reg, status_reg, elem_reg};

    `BPL_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(CAPACITY), "list length above capacity")
    `BPL_ASSERT(a_no_take_in_read, aclk, aresetn, (state_reg == S_READ) |-> !s_tready, "input taken during read-out")
    `BPL_ASSERT(a_ins_grows, aclk, aresetn, (s_accept && d_mode == CM_INS) |=> (count_reg == $past(count_reg) + 1'b1), "insert did not grow the list")
    `BPL_ASSERT(a_read_done, aclk, aresetn, (state_reg == S_READ && out_free && rem_reg == CW'(1)) |=> (state_reg == S_IDLE && m_tvalid && m_tlast), "read-out did not end on its last item")
    `BPL_ASSERT(a_midread_item, aclk, aresetn, (m_tvalid && !m_tlast) |-> (state_reg == S_READ), "non-final item outside read-out")

endmodule

FILE: test/bounded_positional_list_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bounded_positional_list_test - self-checking bench for the positional list
// Drives insert, erase, no-op and read-out requests into the stream input,
// keeps a shadow copy of the list to work out every result item, and checks
// each item taken from the result stream against the oldest one expected.
// ---------------------------------------------------------------------------
module bounded_positional_list_test
    import bpl_pkg::*;
();

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_CYCLES = 200;    // long receiver hold-off

    localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] V_ONES = 32'hFFFF_FFFF;

    // Fields of one result item as the block should present it.
    typedef struct {
        logic [DATA_W-1:0] element;
        status_t           status;
        logic [LEN_W-1:0]  length;
        logic              last;
    } list_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [2:0] func, [8:3] position, [40:9] value
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [31:0] element, [33:32] status,
                                             // [40:34] length
    logic                   m_tlast;

    // Shadow of the list contents and the results still owed by the block.
    logic [DATA_W-1:0] list_cells [LIST_CAP];
    int                list_len;
    list_result_t      pending_results [$];

    int fail_count     = 0;
    int reported       = 0;
    int idle_cycles    = 0;
    int sink_hold_left = 0;
    int src_idle_pct   = 26;
    int sink_idle_pct  = 26;
    bit growing        = 1'b1;   // random traffic leans toward inserts while set

    always #4 aclk = ~aclk;

    bounded_positional_list #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // -----------------------------------------------------------------------
    // List predictor
    // -----------------------------------------------------------------------
    function automatic void push_result(logic [DATA_W-1:0] elem, status_t st, bit last);
        list_result_t r;
        r.element = elem;
        r.status  = st;
        r.length  = LEN_W'(list_len);
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Open a slot at idx by shifting the tail up one cell.
    function automatic void insert_cell(int idx, logic [DATA_W-1:0] v);
        for (int i = list_len; i > idx; i--)
            list_cells[i] = list_cells[i-1];
        list_cells[idx] = v;
        list_len++;
    endfunction

    // Close the slot at idx by shifting the tail down one cell.
    function automatic void remove_cell(int idx);
        for (int i = idx; i + 1 < list_len; i++)
            list_cells[i] = list_cells[i+1];
        list_len--;
    endfunction

    // Apply one accepted request to the shadow list and queue its results.
    function automatic void predict_list_op(func_t f, logic [POS_W-1:0] p,
                                            logic [DATA_W-1:0] v);
        status_t st;
        int      pos;
        st  = STAT_OK;
        pos = int'(p);
        case (f)
            FN_INS_FRONT, FN_INS_END: begin
                if (list_len >= LIST_CAP) st = STAT_FULL;
                else insert_cell(f == FN_INS_FRONT ? 0 : list_len, v);
            end
            FN_ERA_FRONT, FN_ERA_END: begin
                if (list_len == 0) st = STAT_EMPTY;
                else remove_cell(f == FN_ERA_FRONT ? 0 : list_len - 1);
            end
            FN_INS_POS: begin
                // range check wins over the full check
                if (pos < 1 || pos > list_len + 1) st = STAT_RANGE;
                else if (list_len >= LIST_CAP) st = STAT_FULL;
                else insert_cell(pos - 1, v);
            end
            FN_ERA_POS: begin
                if (list_len == 0) st = STAT_EMPTY;
                else if (pos < 1 || pos > list_len) st = STAT_RANGE;
                else remove_cell(pos - 1);
            end
            FN_READ: begin
                if (list_len == 0)
                    push_result('0, STAT_EMPTY, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        push_result(list_cells[i], STAT_OK, i == list_len - 1);
            end
            default: ;
        endcase
        if (f != FN_READ)
            push_result('0, st, 1'b1);
    endfunction

    // -----------------------------------------------------------------------
    // Sender: offer one item from a falling edge, hold it until taken
    // -----------------------------------------------------------------------
    task automatic send_item(func_t f, logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - DATA_W - POS_W - FUNC_W){1'b0}}, v, p, f};
        do @(posedge aclk); while (!s_tready);
        predict_list_op(f, p, v);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return '0;
            3:       return V_ONES;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed requests with in-range positions; a share of noise
    // with any selector and any position.
    task automatic send_random_request();
        logic [FUNC_W-1:0] fsel;
        logic [POS_W-1:0]  p;
        int                r;
        r = $urandom_range(0, 99);
        if (list_len == LIST_CAP) growing = 1'b0;
        if (list_len == 0) growing = 1'b1;
        if (r < 7) begin
            fsel = FUNC_W'($urandom_range(0, 7));
            send_item(func_t'(fsel), POS_W'($urandom_range(0, 63)), random_value());
        end else if (r < 13) begin
            send_item(FN_READ, POS_W'($urandom_range(0, 63)), random_value());
        end else if (r < 15) begin
            send_item(FN_NOP, POS_W'($urandom_range(0, 63)), random_value());
        end else if ($urandom_range(0, 99) < (growing ? 70 : 30)) begin
            p = POS_W'($urandom_range(1, list_len + 1));
            case ($urandom_range(0, 2))
                0:       send_item(FN_INS_FRONT, POS_W'($urandom_range(0, 63)),
                                   random_value());
                1:       send_item(FN_INS_END, POS_W'($urandom_range(0, 63)),
                                   random_value());
                default: send_item(FN_INS_POS, p, random_value());
            endcase
        end else begin
            p = (list_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, list_len));
            case ($urandom_range(0, 2))
                0:       send_item(FN_ERA_FRONT, POS_W'($urandom_range(0, 63)),
                                   random_value());
                1:       send_item(FN_ERA_END, POS_W'($urandom_range(0, 63)),
                                   random_value());
                default: send_item(FN_ERA_POS, p, random_value());
            endcase
        end
    endtask

    // -----------------------------------------------------------------------
    // Receiver: ready changes on the falling edge; a hold-off request
    // forces it low for a counted number of cycles
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        if (sink_hold_left > 0) begin
            m_tready <= 1'b0;
            sink_hold_left--;
        end else begin
            m_tready <= (sink_idle_pct == 0) || ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Result checker: compare each item taken with the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        list_result_t      exp;
        logic [DATA_W-1:0] got_elem;
        logic [STAT_W-1:0] got_stat;
        logic [LEN_W-1:0]  got_len;
        got_elem = m_tdata[DATA_W-1:0];
        got_stat = m_tdata[DATA_W+STAT_W-1:DATA_W];
        got_len  = m_tdata[DATA_W+STAT_W+LEN_W-1:DATA_W+STAT_W];
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("%0t: unexpected result element %0d status %0d length %0d last %0b",
                             $realtime, $signed(got_elem), got_stat, got_len, m_tlast);
                end
            end else begin
                exp = pending_results.pop_front();
                if (got_elem !== exp.element || got_stat !== exp.status ||
                    got_len !== exp.length || m_tlast !== exp.last) begin
                    fail_count++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("%0t: mismatch expected element %0d status %0d length %0d last %0b",
                                 $realtime, $signed(exp.element), exp.status, exp.length,
                                 exp.last);
                        $display("%0t:          actual   element %0d status %0d length %0d last %0b",
                                 $realtime, $signed(got_elem), got_stat, got_len, m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL bounded_positional_list");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Field extremes, every selector and each flagged case on a short list.
    task automatic test_directed_cases();
        send_item(FN_READ, 6'd0, '0);                // read-out of an empty list
        send_item(FN_ERA_FRONT, 6'd0, '0);           // erase from empty
        send_item(FN_ERA_END, 6'd63, V_ONES);
        send_item(FN_ERA_POS, 6'd0, '0);             // empty wins over any position
        send_item(FN_ERA_POS, 6'd63, '0);
        send_item(FN_INS_POS, 6'd0, V_MAX);          // position zero is out of range
        send_item(FN_INS_POS, 6'd2, V_MAX);          // past length+1 on an empty list
        send_item(FN_INS_POS, 6'd1, V_MAX);
        send_item(FN_INS_FRONT, 6'd63, V_MIN);       // position ignored
        send_item(FN_INS_END, 6'd0, V_ONES);
        send_item(FN_INS_POS, 6'd4, '0);             // append at length+1
        send_item(FN_INS_POS, 6'd63, 32'h1234_5678); // out of range
        send_item(FN_ERA_POS, 6'd0, '0);             // out of range on a non-empty list
        send_item(FN_ERA_POS, 6'd5, '0);             // one past the end
        send_item(FN_ERA_POS, 6'd2, V_ONES);         // value ignored
        send_item(FN_NOP, 6'd63, V_ONES);
        send_item(FN_NOP, 6'd0, '0);
        send_item(FN_READ, 6'd63, V_ONES);
        send_item(FN_ERA_END, 6'd0, '0);
        send_item(FN_ERA_FRONT, 6'd0, '0);
        send_item(FN_READ, 6'd0, '0);
    endtask

    // Fill to capacity at random positions, hit the full cases, then empty it.
    task automatic test_full_list();
        while (list_len < LIST_CAP)
            send_item(FN_INS_POS, POS_W'($urandom_range(1, list_len + 1)), random_value());
        send_item(FN_INS_FRONT, 6'd0, V_MAX);
        send_item(FN_INS_END, 6'd0, V_MIN);
        send_item(FN_INS_POS, POS_W'(LIST_CAP + 1), V_ONES); // in range, but full
        send_item(FN_INS_POS, POS_W'(LIST_CAP + 2), V_ONES); // range checked first
        send_item(FN_INS_POS, 6'd0, V_ONES);
        send_item(FN_ERA_POS, POS_W'(LIST_CAP + 1), '0);
        send_item(FN_READ, 6'd0, '0);
        while (list_len > 0) begin
            case ($urandom_range(0, 2))
                0:       send_item(FN_ERA_FRONT, 6'd0, '0);
                1:       send_item(FN_ERA_END, 6'd0, '0);
                default: send_item(FN_ERA_POS, POS_W'($urandom_range(1, list_len)), '0);
            endcase
        end
        send_item(FN_READ, 6'd0, '0);
    endtask

    // Hold the receiver off for a long stretch while items keep coming,
    // so the output register fills and the input stalls.
    task automatic test_output_stall();
        sink_hold_left = HOLD_CYCLES;
        repeat (24) send_random_request();
    endtask

    // Let the sender go quiet until every owed result is back, twice.
    task automatic test_drain_pause();
        repeat (10) send_random_request();
        pause_until_drained();
        repeat (10) send_random_request();
        pause_until_drained();
    endtask

    // Random traffic: a back-to-back stretch first, then random idling.
    task automatic test_random_traffic();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (60) send_random_request();
        src_idle_pct  = 26;
        sink_idle_pct = 26;
        repeat (140) send_random_request();
    endtask

    initial begin
        list_len = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_list();
        test_output_stall();
        test_drain_pause();
        test_random_traffic();

        // Drain: wait for every owed result, then watch for strays.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LIST_CAP + 8) @(posedge aclk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS bounded_positional_list");
        end else begin
            $display("FAIL bounded_positional_list");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bpl_pkg.sv
rtl/bpl_cell.sv
rtl/bounded_positional_list.sv
test/bounded_positional_list_test.sv
